FILE: src/ccrg_pkg.sv
// Shared types, register indexes and pattern tables for the colour cycle ramp generator.
// No dependencies; used by ccrg_divider and colour_cycle_ramp_generator_top.
package ccrg_pkg;

   localparam int PERIOD_W    = 16;
   localparam int PATTERN_W   = 3;
   localparam int LEVEL_W     = 8;
   localparam int CSR_INDEX_W = 8;
   localparam int DIVIDEND_W  = PERIOD_W + LEVEL_W;

   localparam logic [PERIOD_W-1:0]  PERIOD_RESET  = 16'd60;
   localparam logic [PATTERN_W-1:0] PATTERN_RESET = 3'd0;
   localparam logic [LEVEL_W-1:0]   LEVEL_FULL    = 8'hFF;
   localparam logic [LEVEL_W-1:0]   LEVEL_ZERO    = 8'h00;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_RAMP_PERIOD    = 8'd0,
      REG_PATTERN_SELECT = 8'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      CH_ZERO     = 3'd0,
      CH_FULL     = 3'd1,
      CH_UP       = 3'd2,
      CH_DOWN     = 3'd3,
      CH_UPHALF   = 3'd4,
      CH_DOWNHALF = 3'd5
   } chan_kind_type;

   typedef struct packed {
      chan_kind_type red;
      chan_kind_type green;
      chan_kind_type blue;
   } row_type;

   function automatic row_type mk_row(chan_kind_type r, chan_kind_type g, chan_kind_type b);
      row_type row;
      row.red   = r;
      row.green = g;
      row.blue  = b;
      return row;
   endfunction

   // Channel kinds for one pattern and phase; unused patterns give all zero.
   function automatic row_type row_kinds(logic [PATTERN_W-1:0] pattern, logic [1:0] phase);
      row_type row;
      row = mk_row(CH_ZERO, CH_ZERO, CH_ZERO);
      case (pattern)
         3'd0: begin
            case (phase)
               2'd0:    row = mk_row(CH_FULL, CH_UP,   CH_ZERO);
               2'd1:    row = mk_row(CH_FULL, CH_FULL, CH_UP);
               2'd2:    row = mk_row(CH_FULL, CH_FULL, CH_DOWN);
               default: row = mk_row(CH_FULL, CH_DOWN, CH_ZERO);
            endcase
         end
         3'd1: begin
            case (phase)
               2'd0:    row = mk_row(CH_UP,   CH_ZERO, CH_ZERO);
               2'd1:    row = mk_row(CH_FULL, CH_UP,   CH_ZERO);
               2'd2:    row = mk_row(CH_FULL, CH_DOWN, CH_ZERO);
               default: row = mk_row(CH_DOWN, CH_ZERO, CH_ZERO);
            endcase
         end
         3'd2: begin
            case (phase)
               2'd0:    row = mk_row(CH_UP,   CH_FULL, CH_ZERO);
               2'd1:    row = mk_row(CH_FULL, CH_FULL, CH_UP);
               2'd2:    row = mk_row(CH_FULL, CH_FULL, CH_DOWN);
               default: row = mk_row(CH_DOWN, CH_FULL, CH_ZERO);
            endcase
         end
         3'd3: begin
            case (phase)
               2'd0:    row = mk_row(CH_ZERO, CH_UP,   CH_ZERO);
               2'd1:    row = mk_row(CH_UP,   CH_FULL, CH_ZERO);
               2'd2:    row = mk_row(CH_DOWN, CH_FULL, CH_ZERO);
               default: row = mk_row(CH_ZERO, CH_DOWN, CH_ZERO);
            endcase
         end
         3'd4: begin
            case (phase)
               2'd0:    row = mk_row(CH_FULL, CH_DOWNHALF, CH_FULL);
               2'd1:    row = mk_row(CH_FULL, CH_ZERO,     CH_DOWN);
               2'd2:    row = mk_row(CH_FULL, CH_ZERO,     CH_UP);
               default: row = mk_row(CH_FULL, CH_UPHALF,   CH_FULL);
            endcase
         end
         default: row = mk_row(CH_ZERO, CH_ZERO, CH_ZERO);
      endcase
      return row;
   endfunction

   function automatic logic is_ramp(chan_kind_type kind);
      return kind inside {CH_UP, CH_DOWN, CH_UPHALF, CH_DOWNHALF};
   endfunction

   // Level of one channel given the shared ramp quotient.
   function automatic logic [LEVEL_W-1:0] chan_level(chan_kind_type kind,
                                                     logic [LEVEL_W-1:0] quo,
                                                     logic zero_period);
      logic [LEVEL_W-1:0] lvl;
      case (kind)
         CH_FULL:                                lvl = LEVEL_FULL;
         CH_UP, CH_DOWN, CH_UPHALF, CH_DOWNHALF: lvl = zero_period ? LEVEL_ZERO : quo;
         default:                                lvl = LEVEL_ZERO;
      endcase
      return lvl;
   endfunction

endpackage

FILE: src/ccrg_divider.sv
// Iterative restoring divider with 8-bit saturated quotient for the ramp levels.
// One shared 17-bit subtract/compare, one quotient bit per cycle. Uses ccrg_pkg.
module ccrg_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [ccrg_pkg::DIVIDEND_W-1:0]   dividend,
   input  logic [ccrg_pkg::PERIOD_W-1:0]     divisor,
   output logic                              done,
   output logic [ccrg_pkg::LEVEL_W-1:0]      quotient
);

   typedef enum logic [1:0] {
      DV_IDLE,
      DV_CHECK,
      DV_STEP
   } dv_state_type;

   dv_state_type                        state_ff, state_in;
   logic [ccrg_pkg::DIVIDEND_W-1:0]     dvd_ff, dvd_in;
   logic [ccrg_pkg::PERIOD_W-1:0]       rem_ff, rem_in;
   logic [ccrg_pkg::LEVEL_W-1:0]        quo_ff, quo_in;
   logic [2:0]                          bit_ff, bit_in;
   logic                                done_ff, done_in;

   logic [ccrg_pkg::LEVEL_W-1:0]        dvd_low;
   logic [ccrg_pkg::PERIOD_W:0]         cmp_a;
   logic [ccrg_pkg::PERIOD_W+1:0]       diff;
   logic                                ge;

   // Shared compare: the saturation check first, then each quotient bit.
   always_comb begin
      dvd_low = dvd_ff[ccrg_pkg::LEVEL_W-1:0];
      if (state_ff == DV_CHECK) begin
         cmp_a = {1'b0, dvd_ff[ccrg_pkg::DIVIDEND_W-1:ccrg_pkg::LEVEL_W]};
      end else begin
         cmp_a = {rem_ff, dvd_low[bit_ff]};
      end
      diff = {1'b0, cmp_a} - {2'b00, divisor};
      ge   = ~diff[ccrg_pkg::PERIOD_W+1];
   end

   always_comb begin
      state_in = state_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      bit_in   = bit_ff;
      done_in  = 1'b0;
      case (state_ff)
         DV_IDLE: begin
            if (start) begin
               dvd_in   = dividend;
               state_in = DV_CHECK;
            end
         end
         DV_CHECK: begin
            // quotient of 256 or more saturates
            if (ge) begin
               quo_in   = ccrg_pkg::LEVEL_FULL;
               done_in  = 1'b1;
               state_in = DV_IDLE;
            end else begin
               rem_in   = dvd_ff[ccrg_pkg::DIVIDEND_W-1:ccrg_pkg::LEVEL_W];
               quo_in   = '0;
               bit_in   = 3'd7;
               state_in = DV_STEP;
            end
         end
         DV_STEP: begin
            rem_in = ge ? diff[ccrg_pkg::PERIOD_W-1:0] : cmp_a[ccrg_pkg::PERIOD_W-1:0];
            quo_in = {quo_ff[ccrg_pkg::LEVEL_W-2:0], ge};
            bit_in = bit_ff - 3'd1;
            if (bit_ff == 3'd0) begin
               done_in  = 1'b1;
               state_in = DV_IDLE;
            end
         end
         default: state_in = DV_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      bit_ff <= bit_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: src/colour_cycle_ramp_generator_top.sv
// Colour cycle ramp generator: tick counter, phase, pattern lookup and RGB output register.
// An accepted item goes through divider start, saturation check, eight quotient bits,
// quotient handoff and colour register to rsp_valid; a saturated quotient skips the bits.
// One item at a time, waiting in the colour step while a result is still unaccepted;
// req_ready is low while an item is in work. Synchronous reset sets period 60, pattern 0,
// counter and phase to zero; no clearing pass. Uses ccrg_pkg and ccrg_divider.
module colour_cycle_ramp_generator_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_advance,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [ccrg_pkg::LEVEL_W-1:0]        rsp_red_level,
   output logic [ccrg_pkg::LEVEL_W-1:0]        rsp_green_level,
   output logic [ccrg_pkg::LEVEL_W-1:0]        rsp_blue_level,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ccrg_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ccrg_pkg::PERIOD_W-1:0]       csr_wdata
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_RUN,
      ST_DONE
   } state_type;

   state_type                          state_ff, state_in;
   logic [ccrg_pkg::PERIOD_W-1:0]      period_ff, period_in;
   logic [ccrg_pkg::PATTERN_W-1:0]     pattern_ff, pattern_in;
   logic [ccrg_pkg::PERIOD_W-1:0]      tick_ff, tick_in;
   logic [1:0]                         phase_ff, phase_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [ccrg_pkg::LEVEL_W-1:0]       red_ff, red_in;
   logic [ccrg_pkg::LEVEL_W-1:0]       green_ff, green_in;
   logic [ccrg_pkg::LEVEL_W-1:0]       blue_ff, blue_in;

   logic                               req_accept;
   logic [ccrg_pkg::PERIOD_W:0]        tick_next;
   ccrg_pkg::row_type                  row;
   ccrg_pkg::chan_kind_type            ramp_kind;
   logic [ccrg_pkg::PERIOD_W-1:0]      rest;
   logic [ccrg_pkg::PERIOD_W-1:0]      num;
   logic [ccrg_pkg::DIVIDEND_W-1:0]    dividend;
   logic                               zero_period;
   logic                               div_start;
   logic                               div_done;
   logic [ccrg_pkg::LEVEL_W-1:0]       div_quo;

   assign req_ready   = (state_ff == ST_IDLE);
   assign req_accept  = req_valid && req_ready;
   assign csr_ready   = 1'b1;
   assign zero_period = (period_ff == '0);
   assign tick_next   = {1'b0, tick_ff} + {{ccrg_pkg::PERIOD_W{1'b0}}, 1'b1};

   // Each row holds at most one ramp kind, so one division serves all channels.
   always_comb begin
      row = ccrg_pkg::row_kinds(pattern_ff, phase_ff);
      if (ccrg_pkg::is_ramp(row.red)) begin
         ramp_kind = row.red;
      end else if (ccrg_pkg::is_ramp(row.green)) begin
         ramp_kind = row.green;
      end else begin
         ramp_kind = row.blue;
      end
      rest = (period_ff >= tick_ff) ? (period_ff - tick_ff) : '0;
      num  = (ramp_kind == ccrg_pkg::CH_UP || ramp_kind == ccrg_pkg::CH_UPHALF) ? tick_ff : rest;
      if (ramp_kind == ccrg_pkg::CH_UPHALF || ramp_kind == ccrg_pkg::CH_DOWNHALF) begin
         dividend = {1'b0, num, 7'd0};
      end else begin
         // times 255 as times 256 minus one
         dividend = {num, 8'd0} - {8'd0, num};
      end
   end

   assign div_start = (state_ff == ST_PREP);

   ccrg_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (period_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      state_in     = state_ff;
      period_in    = period_ff;
      pattern_in   = pattern_ff;
      tick_in      = tick_ff;
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff;
      red_in       = red_ff;
      green_in     = green_ff;
      blue_in      = blue_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            ccrg_pkg::REG_RAMP_PERIOD:    period_in  = csr_wdata;
            ccrg_pkg::REG_PATTERN_SELECT: pattern_in = csr_wdata[ccrg_pkg::PATTERN_W-1:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_advance) begin
                  if (tick_next >= {1'b0, period_ff}) begin
                     tick_in  = '0;
                     phase_in = phase_ff + 2'd1;
                  end else begin
                     tick_in = tick_next[ccrg_pkg::PERIOD_W-1:0];
                  end
               end
               state_in = ST_PREP;
            end
         end
         ST_PREP: state_in = ST_RUN;
         ST_RUN: begin
            if (div_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               red_in       = ccrg_pkg::chan_level(row.red, div_quo, zero_period);
               green_in     = ccrg_pkg::chan_level(row.green, div_quo, zero_period);
               blue_in      = ccrg_pkg::chan_level(row.blue, div_quo, zero_period);
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         period_ff    <= ccrg_pkg::PERIOD_RESET;
         pattern_ff   <= ccrg_pkg::PATTERN_RESET;
         tick_ff      <= '0;
         phase_ff     <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         period_ff    <= period_in;
         pattern_ff   <= pattern_in;
         tick_ff      <= tick_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_red_level   = red_ff;
   assign rsp_green_level = green_ff;
   assign rsp_blue_level  = blue_ff;

endmodule

FILE: src/ccrg_checker.sv
// Port-level checks for colour_cycle_ramp_generator_top, attached with a bind.
// Depends on ccrg_pkg for widths.
module ccrg_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [ccrg_pkg::LEVEL_W-1:0]     rsp_red_level,
   input logic [ccrg_pkg::LEVEL_W-1:0]     rsp_green_level,
   input logic [ccrg_pkg::LEVEL_W-1:0]     rsp_blue_level
);

   // an accepted item drops req_ready while the block works on it
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready ##1 !req_ready)
      else $error("req_ready returned too soon after an accepted item");

   // a new result only follows a busy period
   a_result_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared without work in progress");

   // no result appears in the cycle right after an item is accepted
   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid)
      else $error("result appeared too early");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_red_level)
         && $stable(rsp_green_level) && $stable(rsp_blue_level))
      else $error("stalled result changed");

endmodule

bind colour_cycle_ramp_generator_top ccrg_checker u_ccrg_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_red_level   (rsp_red_level),
   .rsp_green_level (rsp_green_level),
   .rsp_blue_level  (rsp_blue_level)
);

FILE: dv/colour_cycle_ramp_generator_top_tb.sv
// Self-checking testbench for colour_cycle_ramp_generator_top: a directed script of ticks and
// register writes, then randomized ticks, settings and back-pressure, scored by a colour predictor.
// Depends on ccrg_pkg and the RTL under src/.
module colour_cycle_ramp_generator_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD   = 10;
   localparam int LATENCY      = 12;
   localparam int STALL_LIMIT  = 4000;
   localparam int RANDOM_TICKS = 1600;
   localparam int FULL_SCALE   = 255;
   localparam int HALF_SCALE   = 128;
   localparam logic [ccrg_pkg::CSR_INDEX_W-1:0] CSR_UNUSED = 8'hFF;

   typedef struct packed {
      logic [ccrg_pkg::LEVEL_W-1:0] red;
      logic [ccrg_pkg::LEVEL_W-1:0] green;
      logic [ccrg_pkg::LEVEL_W-1:0] blue;
   } colour_type;

   typedef enum logic { ROW_TICK, ROW_WRITE } row_kind_type;

   typedef struct packed {
      row_kind_type                     kind;
      logic                             advance;
      logic [ccrg_pkg::CSR_INDEX_W-1:0] index;
      logic [ccrg_pkg::PERIOD_W-1:0]    data;
      logic                             typed;
      colour_type                       want;
   } script_row_type;

   typedef enum logic [1:0] { RDY_ALWAYS, RDY_COIN, RDY_EVERY4, RDY_SPARSE } ready_mode_type;

   logic                             clock     = 1'b0;
   logic                             reset     = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   logic                             req_advance = 1'b0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic [ccrg_pkg::LEVEL_W-1:0]     rsp_red_level;
   logic [ccrg_pkg::LEVEL_W-1:0]     rsp_green_level;
   logic [ccrg_pkg::LEVEL_W-1:0]     rsp_blue_level;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [ccrg_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [ccrg_pkg::PERIOD_W-1:0]    csr_wdata = '0;

   // Predictor state, mirrors the block after every accepted item or write.
   logic [ccrg_pkg::PERIOD_W-1:0]  period_q  = ccrg_pkg::PERIOD_RESET;
   logic [ccrg_pkg::PATTERN_W-1:0] pattern_q = ccrg_pkg::PATTERN_RESET;
   logic [ccrg_pkg::PERIOD_W-1:0]  ticks_q   = '0;
   logic [1:0]                     phase_q   = '0;

   colour_type     colour_queue [$];
   int             n_sent   = 0;
   int             n_got    = 0;
   int             n_errors = 0;
   int             stalled  = 0;
   ready_mode_type ready_mode = RDY_ALWAYS;
   int unsigned    mode_left  = 0;

   script_row_type script [36] = '{
      '{ROW_TICK,  1'b0, '0, '0, 1'b1, '{8'd255, 8'd0,   8'd0}},
      '{ROW_TICK,  1'b1, '0, '0, 1'b1, '{8'd255, 8'd4,   8'd0}},
      '{ROW_WRITE, 1'b0, ccrg_pkg::REG_RAMP_PERIOD, 16'd1, 1'b0, '0},
      '{ROW_TICK,  1'b0, '0, '0, 1'b1, '{8'd255, 8'd255, 8'd0}},
      '{ROW_TICK,  1'b1, '0, '0, 1'b1, '{8'd255, 8'd255, 8'd0}},
      '{ROW_TICK,  1'b1, '0, '0, 1'b1, '{8'd255, 8'd255, 8'd255}},
      '{ROW_TICK,  1'b1, '0, '0, 1'b1, '{8'd255, 8'd255, 8'd0}},
      '{ROW_TICK,  1'b1, '0, '0, 1'b1, '{8'd255, 8'd0,   8'd0}},
      // zero period: every advance wraps, ramps read zero
      '{ROW_WRITE, 1'b0, ccrg_pkg::REG_RAMP_PERIOD, 16'd0, 1'b0, '0},
      '{ROW_TICK,  1'b1, '0, '0, 1'b1, '{8'd255, 8'd255, 8'd0}},
      '{ROW_TICK,  1'b0, '0, '0, 1'b1, '{8'd255, 8'd255, 8'd0}},
      '{ROW_WRITE, 1'b0, ccrg_pkg::REG_RAMP_PERIOD, 16'd3, 1'b0, '0},
      '{ROW_TICK,  1'b1, '0, '0, 1'b0, '0},
      '{ROW_TICK,  1'b1, '0, '0, 1'b0, '0},
      // lower the period under the counter: up ramp saturates, down ramp clamps
      '{ROW_WRITE, 1'b0, ccrg_pkg::REG_RAMP_PERIOD, 16'd1, 1'b0, '0},
      '{ROW_TICK,  1'b0, '0, '0, 1'b1, '{8'd255, 8'd255, 8'd255}},
      '{ROW_WRITE, 1'b0, ccrg_pkg::REG_PATTERN_SELECT, 16'd4, 1'b0, '0},
      '{ROW_TICK,  1'b0, '0, '0, 1'b1, '{8'd255, 8'd0,   8'd0}},
      '{ROW_TICK,  1'b1, '0, '0, 1'b0, '0},
      '{ROW_TICK,  1'b1, '0, '0, 1'b1, '{8'd255, 8'd0,   8'd255}},
      '{ROW_TICK,  1'b1, '0, '0, 1'b1, '{8'd255, 8'd128, 8'd255}},
      '{ROW_WRITE, 1'b0, ccrg_pkg::REG_PATTERN_SELECT, 16'd7, 1'b0, '0},
      '{ROW_TICK,  1'b1, '0, '0, 1'b1, '{8'd0,   8'd0,   8'd0}},
      // write to a register that does not exist must change nothing
      '{ROW_WRITE, 1'b0, CSR_UNUSED, 16'hFFFF, 1'b0, '0},
      '{ROW_TICK,  1'b0, '0, '0, 1'b1, '{8'd0,   8'd0,   8'd0}},
      '{ROW_WRITE, 1'b0, ccrg_pkg::REG_PATTERN_SELECT, 16'hFFF9, 1'b0, '0},
      '{ROW_TICK,  1'b0, '0, '0, 1'b0, '0},
      '{ROW_WRITE, 1'b0, ccrg_pkg::REG_PATTERN_SELECT, 16'd2, 1'b0, '0},
      '{ROW_TICK,  1'b1, '0, '0, 1'b0, '0},
      '{ROW_WRITE, 1'b0, ccrg_pkg::REG_PATTERN_SELECT, 16'd3, 1'b0, '0},
      '{ROW_WRITE, 1'b0, ccrg_pkg::REG_RAMP_PERIOD, 16'hFFFF, 1'b0, '0},
      '{ROW_TICK,  1'b1, '0, '0, 1'b0, '0},
      '{ROW_WRITE, 1'b0, ccrg_pkg::REG_PATTERN_SELECT, 16'd5, 1'b0, '0},
      '{ROW_TICK,  1'b0, '0, '0, 1'b1, '{8'd0,   8'd0,   8'd0}},
      '{ROW_WRITE, 1'b0, ccrg_pkg::REG_PATTERN_SELECT, 16'd6, 1'b0, '0},
      '{ROW_TICK,  1'b0, '0, '0, 1'b1, '{8'd0,   8'd0,   8'd0}}
   };

   colour_cycle_ramp_generator_top u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_advance     (req_advance),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_red_level   (rsp_red_level),
      .rsp_green_level (rsp_green_level),
      .rsp_blue_level  (rsp_blue_level),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Channel kinds red, green, blue for one pattern and phase.
   function automatic logic [8:0] pattern_kinds(logic [ccrg_pkg::PATTERN_W-1:0] pat,
                                                logic [1:0] ph);
      case ({pat, ph})
         {3'd0, 2'd0}: return {ccrg_pkg::CH_FULL, ccrg_pkg::CH_UP, ccrg_pkg::CH_ZERO};
         {3'd0, 2'd1}: return {ccrg_pkg::CH_FULL, ccrg_pkg::CH_FULL, ccrg_pkg::CH_UP};
         {3'd0, 2'd2}: return {ccrg_pkg::CH_FULL, ccrg_pkg::CH_FULL, ccrg_pkg::CH_DOWN};
         {3'd0, 2'd3}: return {ccrg_pkg::CH_FULL, ccrg_pkg::CH_DOWN, ccrg_pkg::CH_ZERO};
         {3'd1, 2'd0}: return {ccrg_pkg::CH_UP, ccrg_pkg::CH_ZERO, ccrg_pkg::CH_ZERO};
         {3'd1, 2'd1}: return {ccrg_pkg::CH_FULL, ccrg_pkg::CH_UP, ccrg_pkg::CH_ZERO};
         {3'd1, 2'd2}: return {ccrg_pkg::CH_FULL, ccrg_pkg::CH_DOWN, ccrg_pkg::CH_ZERO};
         {3'd1, 2'd3}: return {ccrg_pkg::CH_DOWN, ccrg_pkg::CH_ZERO, ccrg_pkg::CH_ZERO};
         {3'd2, 2'd0}: return {ccrg_pkg::CH_UP, ccrg_pkg::CH_FULL, ccrg_pkg::CH_ZERO};
         {3'd2, 2'd1}: return {ccrg_pkg::CH_FULL, ccrg_pkg::CH_FULL, ccrg_pkg::CH_UP};
         {3'd2, 2'd2}: return {ccrg_pkg::CH_FULL, ccrg_pkg::CH_FULL, ccrg_pkg::CH_DOWN};
         {3'd2, 2'd3}: return {ccrg_pkg::CH_DOWN, ccrg_pkg::CH_FULL, ccrg_pkg::CH_ZERO};
         {3'd3, 2'd0}: return {ccrg_pkg::CH_ZERO, ccrg_pkg::CH_UP, ccrg_pkg::CH_ZERO};
         {3'd3, 2'd1}: return {ccrg_pkg::CH_UP, ccrg_pkg::CH_FULL, ccrg_pkg::CH_ZERO};
         {3'd3, 2'd2}: return {ccrg_pkg::CH_DOWN, ccrg_pkg::CH_FULL, ccrg_pkg::CH_ZERO};
         {3'd3, 2'd3}: return {ccrg_pkg::CH_ZERO, ccrg_pkg::CH_DOWN, ccrg_pkg::CH_ZERO};
         {3'd4, 2'd0}: return {ccrg_pkg::CH_FULL, ccrg_pkg::CH_DOWNHALF, ccrg_pkg::CH_FULL};
         {3'd4, 2'd1}: return {ccrg_pkg::CH_FULL, ccrg_pkg::CH_ZERO, ccrg_pkg::CH_DOWN};
         {3'd4, 2'd2}: return {ccrg_pkg::CH_FULL, ccrg_pkg::CH_ZERO, ccrg_pkg::CH_UP};
         {3'd4, 2'd3}: return {ccrg_pkg::CH_FULL, ccrg_pkg::CH_UPHALF, ccrg_pkg::CH_FULL};
         default:      return {ccrg_pkg::CH_ZERO, ccrg_pkg::CH_ZERO, ccrg_pkg::CH_ZERO};
      endcase
   endfunction

   function automatic logic [ccrg_pkg::LEVEL_W-1:0] level_of(ccrg_pkg::chan_kind_type kind);
      int unsigned rest;
      int unsigned num;
      int unsigned scale;
      int unsigned q;
      rest  = (period_q >= ticks_q) ? period_q - ticks_q : 0;
      num   = 0;
      scale = 0;
      case (kind)
         ccrg_pkg::CH_FULL:     return ccrg_pkg::LEVEL_FULL;
         ccrg_pkg::CH_UP:       begin num = ticks_q; scale = FULL_SCALE; end
         ccrg_pkg::CH_DOWN:     begin num = rest;    scale = FULL_SCALE; end
         ccrg_pkg::CH_UPHALF:   begin num = ticks_q; scale = HALF_SCALE; end
         ccrg_pkg::CH_DOWNHALF: begin num = rest;    scale = HALF_SCALE; end
         default:               return ccrg_pkg::LEVEL_ZERO;
      endcase
      if (period_q == '0) return ccrg_pkg::LEVEL_ZERO;
      q = (num * scale) / period_q;
      return (q > FULL_SCALE) ? ccrg_pkg::LEVEL_FULL : q[ccrg_pkg::LEVEL_W-1:0];
   endfunction

   // Advance the counter and phase for one tick when adv is set, then work out the colour.
   task automatic step_colour(input logic adv, output colour_type c);
      logic [ccrg_pkg::PERIOD_W:0] next_ticks;
      logic [8:0]                  kinds;
      if (adv) begin
         next_ticks = ticks_q + 1'b1;
         if (next_ticks >= period_q) begin
            ticks_q = '0;
            phase_q = phase_q + 1'b1;
         end else begin
            ticks_q = next_ticks[ccrg_pkg::PERIOD_W-1:0];
         end
      end
      kinds   = pattern_kinds(pattern_q, phase_q);
      c.red   = level_of(ccrg_pkg::chan_kind_type'(kinds[8:6]));
      c.green = level_of(ccrg_pkg::chan_kind_type'(kinds[5:3]));
      c.blue  = level_of(ccrg_pkg::chan_kind_type'(kinds[2:0]));
   endtask

   // Leaves req_valid high so the next item can follow without a gap.
   task automatic push_tick(input logic adv, input logic typed, input colour_type want);
      colour_type c;
      req_valid   <= 1'b1;
      req_advance <= adv;
      do @(posedge clock); while (!req_ready);
      n_sent++;
      step_colour(adv, c);
      colour_queue.push_back(typed ? want : c);
   endtask

   task automatic csr_write(input logic [ccrg_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [ccrg_pkg::PERIOD_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == ccrg_pkg::REG_RAMP_PERIOD) period_q = data;
      else if (idx == ccrg_pkg::REG_PATTERN_SELECT) pattern_q = data[ccrg_pkg::PATTERN_W-1:0];
      @(posedge clock);
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (n_got < n_sent);
   endtask

   task automatic write_random_settings();
      logic [ccrg_pkg::PERIOD_W-1:0]  period_v;
      logic [ccrg_pkg::PATTERN_W-1:0] pattern_v;
      case ($urandom_range(0, 9))
         0:       period_v = '0;
         1:       period_v = '1;
         2:       period_v = 16'($urandom);
         3:       period_v = 16'd1;
         default: period_v = 16'($urandom_range(2, 40));
      endcase
      if ($urandom_range(0, 5) == 0) pattern_v = 3'($urandom_range(5, 7));
      else pattern_v = 3'($urandom_range(0, 4));
      if ($urandom_range(0, 3) == 0) csr_write(8'($urandom_range(2, 255)), 16'($urandom));
      if ($urandom_range(0, 1) == 0) begin
         csr_write(ccrg_pkg::REG_RAMP_PERIOD, period_v);
         csr_write(ccrg_pkg::REG_PATTERN_SELECT, {13'($urandom), pattern_v});
      end else begin
         csr_write(ccrg_pkg::REG_PATTERN_SELECT, {13'($urandom), pattern_v});
         csr_write(ccrg_pkg::REG_RAMP_PERIOD, period_v);
      end
   endtask

   task automatic check_level(input string name, input logic [ccrg_pkg::LEVEL_W-1:0] want,
                              input logic [ccrg_pkg::LEVEL_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         n_errors++;
      end
   endtask

   // Receiver back-pressure: switch between a few stall patterns every so often.
   always @(posedge clock) begin
      if (mode_left == 0) begin
         ready_mode <= ready_mode_type'($urandom_range(0, 3));
         mode_left  <= $urandom_range(16, 160);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (ready_mode)
         RDY_ALWAYS: rsp_ready <= 1'b1;
         RDY_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
         RDY_EVERY4: rsp_ready <= (mode_left[1:0] == 2'd0);
         default:    rsp_ready <= ($urandom_range(0, 11) == 0);
      endcase
   end

   // Score results and watch for a hung handshake.
   always @(posedge clock) begin : score
      colour_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            n_got++;
            if (colour_queue.size() == 0) begin
               $error("colour result %0d/%0d/%0d with nothing pending",
                      rsp_red_level, rsp_green_level, rsp_blue_level);
               n_errors++;
            end else begin
               want = colour_queue.pop_front();
               check_level("red_level", want.red, rsp_red_level);
               check_level("green_level", want.green, rsp_green_level);
               check_level("blue_level", want.blue, rsp_blue_level);
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
            stalled = 0;
         end else begin
            stalled++;
            if (stalled >= STALL_LIMIT) begin
               $display("TB_ERROR");
               $finish;
            end
         end
      end
   end

   initial begin
      int done_ticks;
      int phase_target;
      int burst;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[i]) begin
         if (script[i].kind == ROW_WRITE) begin
            req_valid <= 1'b0;
            wait_drained();
            csr_write(script[i].index, script[i].data);
         end else begin
            push_tick(script[i].advance, script[i].typed, script[i].want);
         end
      end

      done_ticks = 0;
      while (done_ticks < RANDOM_TICKS) begin
         // settings change only with the block idle
         req_valid <= 1'b0;
         wait_drained();
         write_random_settings();
         phase_target = $urandom_range(60, 200);
         while (phase_target > 0 && done_ticks < RANDOM_TICKS) begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst; k++) push_tick($urandom_range(0, 3) != 0, 1'b0, '0);
            done_ticks   += burst;
            phase_target -= burst;
            case ($urandom_range(0, 9))
               0, 1, 2: ;
               3: begin
                  req_valid <= 1'b0;
                  wait_drained();
               end
               default: begin
                  req_valid <= 1'b0;
                  repeat ($urandom_range(1, 12)) @(posedge clock);
               end
            endcase
         end
      end

      req_valid <= 1'b0;
      wait_drained();
      repeat (LATENCY + 8) @(posedge clock);
      if (colour_queue.size() != 0) begin
         $error("%0d colour results never arrived", colour_queue.size());
         n_errors++;
      end
      if (n_errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
